>>> rtl/flash_image_programmer_macros.svh
// Assertion macros for the flash image programmer checker.
// Used only by the checker file; expects clk and rst in scope.
`ifndef FLASH_IMAGE_PROGRAMMER_MACROS_SVH
`define FLASH_IMAGE_PROGRAMMER_MACROS_SVH

// Same-cycle implication, masked during reset.
`define FIP_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, masked during reset.
`define FIP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/fip_pkg.sv
// Shared types, codes and the CRC-32 byte step for the flash image programmer.
// No dependencies.
`default_nettype none

package fip_pkg;

  localparam logic [31:0] CrcPoly         = 32'hEDB8_8320;
  localparam logic [31:0] AllOnes32       = 32'hFFFF_FFFF;
  localparam logic [63:0] AllOnes64       = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [31:0] BaseAddrReset   = 32'd134250496;
  localparam logic [31:0] MaxLenReset     = 32'd481280;
  localparam logic [7:0]  FirstPageReset  = 8'd16;
  localparam logic [7:0]  LastPageReset   = 8'd250;
  localparam logic [31:0] DwordBytes      = 32'd8;

  typedef enum logic [2:0] {
    CMD_BEGIN     = 3'd0,
    CMD_WRITE     = 3'd1,
    CMD_VERIFY    = 3'd2,
    CMD_ABORT     = 3'd3,
    CMD_FLASH_ERR = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    OP_NONE    = 2'd0,
    OP_ERASE   = 2'd1,
    OP_PROGRAM = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    MODE_IDLE        = 3'd0,
    MODE_ERASING     = 3'd1,
    MODE_PROGRAMMING = 3'd2,
    MODE_VERIFYING   = 3'd3,
    MODE_FAULT       = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    CFG_BASE_ADDR  = 2'd0,
    CFG_MAX_LEN    = 2'd1,
    CFG_FIRST_PAGE = 2'd2,
    CFG_LAST_PAGE  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0] image_base_address;
    logic [31:0] image_max_length;
    logic [7:0]  erase_first_page;
    logic [7:0]  erase_last_page;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  data_byte;
    logic [31:0] image_length;
    logic [31:0] expected_crc;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  flash_op;
    logic [31:0] program_address;
    logic [63:0] program_data;
    logic [7:0]  range_first_page;
    logic [7:0]  range_last_page;
    logic        accepted;
    logic [2:0]  machine_state;
  } out_item_t;

  function automatic logic [31:0] crc_byte(logic [31:0] crc_in, logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/flash_image_programmer.sv
// Top level of the flash image programmer: input register, engine, result register.
// Depends on fip_pkg, fip_cfg_regs and fip_engine.
//
//   channel  | signals                          | transfer rule
//   ---------+----------------------------------+------------------------------
//   command  | in_valid, in_stall, in_data      | in_valid and not in_stall
//   result   | out_valid, out_stall, out_data   | out_valid and not out_stall
//   config   | cfg_write, cfg_index, cfg_data   | cfg_write
//
// One command per cycle unless stalled; each yields one result via both registers.
// The engine's update of mode, buffer and CRC for each command bounds the rate.
// rst is synchronous; it empties both registers and restores all state.
// A stalled result holds the result register; the input register then fills
// and in_stall rises until the result moves on.
`default_nettype none

module flash_image_programmer (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire fip_pkg::in_item_t  in_data,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output fip_pkg::out_item_t      out_data,
  input  wire logic               cfg_write,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  fip_pkg::cfg_t      cfg;
  fip_pkg::in_item_t  in_reg;
  fip_pkg::out_item_t result;
  logic               in_full;
  logic               advance;

  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;

  fip_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fip_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (in_reg),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_reg <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire

>>> rtl/fip_cfg_regs.sv
// Configuration register file for the flash image programmer.
// Depends on fip_pkg.
`default_nettype none

module fip_cfg_regs (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_write,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [31:0]  cfg_data,
  output fip_pkg::cfg_t     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_base_address <= fip_pkg::BaseAddrReset;
      cfg.image_max_length   <= fip_pkg::MaxLenReset;
      cfg.erase_first_page   <= fip_pkg::FirstPageReset;
      cfg.erase_last_page    <= fip_pkg::LastPageReset;
    end else if (cfg_write) begin
      unique case (cfg_index)
        fip_pkg::CFG_BASE_ADDR:  cfg.image_base_address <= cfg_data;
        fip_pkg::CFG_MAX_LEN:    cfg.image_max_length   <= cfg_data;
        fip_pkg::CFG_FIRST_PAGE: cfg.erase_first_page   <= cfg_data[7:0];
        fip_pkg::CFG_LAST_PAGE:  cfg.erase_last_page    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/fip_engine.sv
// Command engine: session state, doubleword packing, CRC and mode control.
// Depends on fip_pkg; one command is processed per step.
`default_nettype none

module fip_engine (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               step,
  input  wire fip_pkg::in_item_t  item,
  input  wire fip_pkg::cfg_t      cfg,
  output fip_pkg::out_item_t      result
);

  fip_pkg::mode_e mode, mode_next;
  logic [31:0] write_cursor, write_cursor_next;
  logic [31:0] expected_length, expected_length_next;
  logic [31:0] bytes_accepted, bytes_accepted_next;
  logic [63:0] word_buffer, word_buffer_next;
  logic [2:0]  buffer_fill, buffer_fill_next;
  logic [31:0] running_crc, running_crc_next;

  logic        in_prog;
  logic        begin_ok_state;
  logic        len_bad;
  logic        overrun;
  logic        all_in;
  logic        crc_match;
  logic        flush;
  logic [31:0] bytes_plus;
  logic [63:0] merged;

  assign in_prog        = (mode == fip_pkg::MODE_PROGRAMMING);
  assign begin_ok_state = (mode == fip_pkg::MODE_IDLE) || (mode == fip_pkg::MODE_FAULT);
  assign len_bad        = (item.image_length == 32'd0) ||
                          (item.image_length > cfg.image_max_length);
  assign overrun        = (bytes_accepted >= expected_length);
  assign all_in         = (bytes_accepted == expected_length);
  assign crc_match      = (~running_crc == item.expected_crc);
  assign bytes_plus     = bytes_accepted + 32'd1;
  assign flush          = (buffer_fill == 3'd7) || (bytes_plus == expected_length);

  always_comb begin
    merged = word_buffer;
    for (int i = 0; i < 8; i++) begin
      if (buffer_fill == 3'(i)) begin
        merged[8*i +: 8] = item.data_byte;
      end
    end
  end

  always_comb begin
    mode_next = mode;
    unique case (item.cmd)
      fip_pkg::CMD_BEGIN: begin
        if (begin_ok_state) begin
          mode_next = len_bad ? fip_pkg::MODE_FAULT : fip_pkg::MODE_PROGRAMMING;
        end
      end
      fip_pkg::CMD_WRITE: begin
        if (in_prog && overrun) begin
          mode_next = fip_pkg::MODE_FAULT;
        end
      end
      fip_pkg::CMD_VERIFY: begin
        if (in_prog) begin
          mode_next = (all_in && crc_match) ? fip_pkg::MODE_IDLE : fip_pkg::MODE_FAULT;
        end
      end
      fip_pkg::CMD_ABORT:     mode_next = fip_pkg::MODE_IDLE;
      fip_pkg::CMD_FLASH_ERR: mode_next = fip_pkg::MODE_FAULT;
      default: ;
    endcase
  end

  always_comb begin
    result                 = '0;
    write_cursor_next      = write_cursor;
    expected_length_next   = expected_length;
    bytes_accepted_next    = bytes_accepted;
    word_buffer_next       = word_buffer;
    buffer_fill_next       = buffer_fill;
    running_crc_next       = running_crc;
    unique case (item.cmd)
      fip_pkg::CMD_BEGIN: begin
        if (begin_ok_state && !len_bad) begin
          write_cursor_next       = cfg.image_base_address;
          expected_length_next    = item.image_length;
          bytes_accepted_next     = 32'd0;
          word_buffer_next        = fip_pkg::AllOnes64;
          buffer_fill_next        = 3'd0;
          running_crc_next        = fip_pkg::AllOnes32;
          result.flash_op         = fip_pkg::OP_ERASE;
          result.range_first_page = cfg.erase_first_page;
          result.range_last_page  = cfg.erase_last_page;
          result.accepted         = 1'b1;
        end
      end
      fip_pkg::CMD_WRITE: begin
        if (in_prog && !overrun) begin
          bytes_accepted_next = bytes_plus;
          running_crc_next    = fip_pkg::crc_byte(running_crc, item.data_byte);
          result.accepted     = 1'b1;
          if (flush) begin
            result.flash_op        = fip_pkg::OP_PROGRAM;
            result.program_address = write_cursor;
            result.program_data    = merged;
            write_cursor_next      = write_cursor + fip_pkg::DwordBytes;
            buffer_fill_next       = 3'd0;
            word_buffer_next       = fip_pkg::AllOnes64;
          end else begin
            buffer_fill_next = buffer_fill + 3'd1;
            word_buffer_next = merged;
          end
        end
      end
      fip_pkg::CMD_VERIFY: begin
        result.accepted = in_prog && all_in && crc_match;
      end
      fip_pkg::CMD_ABORT: begin
        write_cursor_next    = cfg.image_base_address;
        expected_length_next = 32'd0;
        bytes_accepted_next  = 32'd0;
        word_buffer_next     = fip_pkg::AllOnes64;
        buffer_fill_next     = 3'd0;
        running_crc_next     = fip_pkg::AllOnes32;
        result.accepted      = 1'b1;
      end
      default: ;
    endcase
    result.machine_state = mode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= fip_pkg::MODE_IDLE;
      write_cursor    <= fip_pkg::BaseAddrReset;
      expected_length <= 32'd0;
      bytes_accepted  <= 32'd0;
      word_buffer     <= fip_pkg::AllOnes64;
      buffer_fill     <= 3'd0;
      running_crc     <= fip_pkg::AllOnes32;
    end else if (step) begin
      mode            <= mode_next;
      write_cursor    <= write_cursor_next;
      expected_length <= expected_length_next;
      bytes_accepted  <= bytes_accepted_next;
      word_buffer     <= word_buffer_next;
      buffer_fill     <= buffer_fill_next;
      running_crc     <= running_crc_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/fip_checker.sv
// Port-level checker for the flash image programmer, bound to the top level.
// Depends on fip_pkg and flash_image_programmer_macros.svh.
`default_nettype none
`include "flash_image_programmer_macros.svh"

module fip_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire fip_pkg::out_item_t out_data
);

  `FIP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  `FIP_ASSERT_IMPLY(a_erase_enters_prog, out_valid && out_data.flash_op == fip_pkg::OP_ERASE, out_data.accepted && out_data.machine_state == fip_pkg::MODE_PROGRAMMING)

  `FIP_ASSERT_IMPLY(a_idle_op_clean, out_valid && out_data.flash_op == fip_pkg::OP_NONE, out_data.program_address == 32'd0 && out_data.program_data == 64'd0)

  `FIP_ASSERT_IMPLY(a_fault_refuses, out_valid && out_data.machine_state == fip_pkg::MODE_FAULT, !out_data.accepted)

endmodule

bind flash_image_programmer fip_checker u_fip_checker (.*);

`default_nettype wire

>>> dv/flash_image_programmer_test.sv
// Self-checking testbench for flash_image_programmer: a directed set of commands and then
// random programming sessions under several register settings, each result checked against
// a predictor built in. Depends on fip_pkg and the flash_image_programmer RTL.
module flash_image_programmer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fip_pkg::*;

  localparam logic [2:0] CmdFirstUnused = 3'd5;
  localparam logic [2:0] CmdLastUnused  = 3'd7;

  typedef enum {SHAPE_SHORT, SHAPE_OVERRUN, SHAPE_ABORT, SHAPE_FLASH_ERR, SHAPE_CLEAN}
    session_shape_e;
  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BLOCK} stall_style_e;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_data;
  logic       cfg_write = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  flash_image_programmer DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Predictor state
  cfg_t        model_cfg;
  mode_e       prog_mode;
  logic [31:0] cursor;
  logic [31:0] length_goal;
  logic [31:0] byte_count;
  logic [63:0] dword_buf;
  logic [3:0]  fill;
  logic [31:0] crc_acc;

  in_item_t  command_queue[$];
  out_item_t responses_due[$];
  int        mismatches = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  stall_style_e stall_style = STALL_NONE;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [31:0] crc32_advance(logic [31:0] acc, logic [7:0] b);
    logic [31:0] c;
    c = acc;
    for (int i = 0; i < 8; i++) begin
      if (c[0] ^ b[i]) c = (c >> 1) ^ CrcPoly;
      else c = c >> 1;
    end
    return c;
  endfunction

  function automatic void clear_session();
    cursor = model_cfg.image_base_address;
    length_goal = '0;
    byte_count = '0;
    dword_buf = AllOnes64;
    fill = '0;
    crc_acc = AllOnes32;
  endfunction

  function automatic out_item_t program_step(in_item_t item);
    out_item_t r;
    r = '0;
    case (item.cmd)
      CMD_BEGIN: begin
        if (prog_mode == MODE_IDLE || prog_mode == MODE_FAULT) begin
          if (item.image_length == '0 || item.image_length > model_cfg.image_max_length) begin
            prog_mode = MODE_FAULT;
          end else begin
            clear_session();
            length_goal = item.image_length;
            r.flash_op = OP_ERASE;
            r.range_first_page = model_cfg.erase_first_page;
            r.range_last_page = model_cfg.erase_last_page;
            prog_mode = MODE_PROGRAMMING;
            r.accepted = 1'b1;
          end
        end
      end
      CMD_WRITE: begin
        if (prog_mode == MODE_PROGRAMMING) begin
          if (byte_count >= length_goal) begin
            prog_mode = MODE_FAULT;
          end else begin
            dword_buf[{fill[2:0], 3'b000} +: 8] = item.data_byte;
            fill = fill + 4'd1;
            byte_count = byte_count + 32'd1;
            crc_acc = crc32_advance(crc_acc, item.data_byte);
            if (fill >= 4'd8 || byte_count == length_goal) begin
              r.flash_op = OP_PROGRAM;
              r.program_address = cursor;
              r.program_data = dword_buf;
              cursor = cursor + DwordBytes;
              fill = '0;
              dword_buf = AllOnes64;
            end
            r.accepted = 1'b1;
          end
        end
      end
      CMD_VERIFY: begin
        if (prog_mode == MODE_PROGRAMMING) begin
          if (byte_count != length_goal || ~crc_acc != item.expected_crc) begin
            prog_mode = MODE_FAULT;
          end else begin
            prog_mode = MODE_IDLE;
            r.accepted = 1'b1;
          end
        end
      end
      CMD_ABORT: begin
        prog_mode = MODE_IDLE;
        clear_session();
        r.accepted = 1'b1;
      end
      CMD_FLASH_ERR: prog_mode = MODE_FAULT;
      default: ;
    endcase
    r.machine_state = prog_mode;
    return r;
  endfunction

  function automatic void push_cmd(logic [2:0] c, logic [7:0] b, logic [31:0] n,
                                   logic [31:0] e);
    in_item_t it;
    it.cmd = c;
    it.data_byte = b;
    it.image_length = n;
    it.expected_crc = e;
    command_queue.push_back(it);
  endfunction

  function automatic int queue_session(int unsigned len_cap);
    logic [31:0] len, crc;
    int unsigned writes, cut;
    session_shape_e shape;
    int made;
    logic [7:0] b;
    made = 1;
    crc = AllOnes32;
    shape = session_shape_e'($urandom_range(0, 19));
    if (shape > SHAPE_CLEAN) shape = SHAPE_CLEAN;
    len = $urandom_range(1, ($urandom_range(0, 15) == 0) ? len_cap * 4 : len_cap);
    if ($urandom_range(0, 11) == 0) len = model_cfg.image_max_length + 32'd1;
    writes = (len > len_cap * 4) ? len_cap : len;
    if ($urandom_range(0, 3) == 0) begin
      push_cmd(CMD_ABORT, 8'($urandom), $urandom, $urandom);
      made++;
    end
    push_cmd(CMD_BEGIN, 8'($urandom), len, $urandom);
    cut = $urandom_range(0, writes);
    if (shape == SHAPE_SHORT) writes = cut;
    if (shape == SHAPE_OVERRUN) writes += $urandom_range(1, 3);
    for (int unsigned i = 0; i <= writes; i++) begin
      if ((shape == SHAPE_ABORT || shape == SHAPE_FLASH_ERR) && i == cut) begin
        push_cmd(shape == SHAPE_ABORT ? CMD_ABORT : CMD_FLASH_ERR, 8'($urandom), $urandom,
                 $urandom);
        return made + 1;
      end
      if (i < writes) begin
        if ($urandom_range(0, 39) == 0) begin
          if ($urandom_range(0, 1) != 0)
            push_cmd(3'($urandom_range(CmdFirstUnused, CmdLastUnused)), 8'($urandom),
                     $urandom, $urandom);
          else
            push_cmd(CMD_BEGIN, 8'($urandom), $urandom_range(1, 8), $urandom);
        end
        b = 8'($urandom);
        crc = crc32_advance(crc, b);
        push_cmd(CMD_WRITE, b, $urandom, $urandom);
        made++;
      end
    end
    push_cmd(CMD_VERIFY, 8'($urandom), $urandom,
             ($urandom_range(0, 9) == 0) ? (~crc ^ ($urandom | 32'd1)) : ~crc);
    return made + 1;
  endfunction

  function automatic int queue_noise();
    int unsigned n;
    n = $urandom_range(1, 4);
    for (int unsigned i = 0; i < n; i++)
      push_cmd(3'($urandom), 8'($urandom),
               ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 64), $urandom);
    push_cmd(CMD_ABORT, 8'($urandom), $urandom, $urandom);
    return n + 1;
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [31:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      CFG_BASE_ADDR:  model_cfg.image_base_address = value;
      CFG_MAX_LEN:    model_cfg.image_max_length = value;
      CFG_FIRST_PAGE: model_cfg.erase_first_page = value[7:0];
      CFG_LAST_PAGE:  model_cfg.erase_last_page = value[7:0];
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic write_all(logic [31:0] base, logic [31:0] max_len, logic [7:0] first,
                           logic [7:0] last);
    write_reg(CFG_BASE_ADDR, base);
    write_reg(CFG_MAX_LEN, max_len);
    write_reg(CFG_FIRST_PAGE, {24'd0, first});
    write_reg(CFG_LAST_PAGE, {24'd0, last});
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (command_queue.size() != 0 || in_valid || responses_due.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(int budget, int unsigned len_cap);
    int made;
    made = 0;
    @(negedge clk);
    while (made < budget) begin
      if ($urandom_range(0, 6) == 0) made += queue_noise();
      else made += queue_session(len_cap);
    end
    wait_drained();
  endtask

  // Sender: bursts of transactions separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        responses_due.push_back(program_step(in_data));
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0 || command_queue.size() == 0) begin
          if (gap_left != 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          in_data <= command_queue.pop_front();
          in_valid <= 1'b1;
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 200)
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  // Receiver: check each result transaction, stall on a pattern of its own
  always @(posedge clk) begin : result_monitor
    out_item_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (responses_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 200)
            $display("%0t: result expected none actual %h", $time, out_data);
        end else begin
          want = responses_due.pop_front();
          check_field("flash_op", 64'(want.flash_op), 64'(out_data.flash_op));
          check_field("program_address", 64'(want.program_address),
                      64'(out_data.program_address));
          check_field("program_data", want.program_data, out_data.program_data);
          check_field("range_first_page", 64'(want.range_first_page),
                      64'(out_data.range_first_page));
          check_field("range_last_page", 64'(want.range_last_page),
                      64'(out_data.range_last_page));
          check_field("accepted", 64'(want.accepted), 64'(out_data.accepted));
          check_field("machine_state", 64'(want.machine_state),
                      64'(out_data.machine_state));
        end
      end
      if (stall_left == 0) begin
        stall_style = stall_style_e'($urandom_range(0, 3));
        stall_left = $urandom_range(5, 60);
      end else begin
        stall_left--;
      end
      case (stall_style)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 4) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= (stall_left < 12);
      endcase
    end
  end

  initial begin
    #10ms;
    $display("flash_image_programmer_test: errors");
    $finish;
  end

  initial begin
    logic [31:0] one_crc;
    model_cfg = '{BaseAddrReset, MaxLenReset, FirstPageReset, LastPageReset};
    prog_mode = MODE_IDLE;
    clear_session();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    push_cmd(CmdLastUnused, 8'hFF, AllOnes32, AllOnes32);
    push_cmd(CMD_WRITE, 8'h00, '0, '0);
    push_cmd(CMD_VERIFY, 8'h00, '0, '0);
    push_cmd(CMD_ABORT, 8'h00, '0, '0);
    push_cmd(CMD_BEGIN, 8'h00, '0, '0);
    push_cmd(CMD_BEGIN, 8'h00, MaxLenReset + 32'd1, '0);
    push_cmd(CMD_FLASH_ERR, 8'h00, '0, '0);
    push_cmd(CMD_BEGIN, 8'h00, 32'd9, '0);
    push_cmd(CMD_BEGIN, 8'h00, 32'd3, '0);
    push_cmd(CMD_WRITE, 8'h00, '0, '0);
    push_cmd(CMD_WRITE, 8'hFF, '0, '0);
    push_cmd(CMD_WRITE, 8'h5A, '0, '0);
    push_cmd(CMD_WRITE, 8'hA5, '0, '0);
    push_cmd(CMD_WRITE, 8'h01, '0, '0);
    push_cmd(CMD_WRITE, 8'h80, '0, '0);
    push_cmd(CMD_WRITE, 8'h7F, '0, '0);
    push_cmd(CMD_WRITE, 8'hFE, '0, '0);
    push_cmd(CMD_WRITE, 8'h3C, '0, '0);
    push_cmd(CMD_WRITE, 8'hC3, '0, '0);
    push_cmd(CMD_BEGIN, 8'h00, MaxLenReset, '0);
    push_cmd(CmdFirstUnused, 8'h00, '0, '0);
    push_cmd(CMD_WRITE, 8'h42, '0, '0);
    push_cmd(CMD_VERIFY, 8'h00, '0, '0);
    push_cmd(CMD_BEGIN, 8'h00, 32'd1, '0);
    push_cmd(CMD_WRITE, 8'h99, '0, '0);
    push_cmd(CMD_VERIFY, 8'h00, '0, '0);
    one_crc = ~crc32_advance(AllOnes32, 8'hE7);
    push_cmd(CMD_BEGIN, 8'h00, 32'd1, '0);
    push_cmd(CMD_WRITE, 8'hE7, '0, '0);
    push_cmd(CMD_VERIFY, 8'h00, '0, one_crc);
    wait_drained();

    run_phase(500, 24);
    write_all('0, 32'd1, 8'h00, 8'h00);
    run_phase(200, 3);
    write_all(32'hFFFF_FFF3, AllOnes32, 8'hFF, 8'h00);
    run_phase(400, 40);
    write_all(32'h0000_1000, 32'd64, 8'hFF, 8'hFF);
    run_phase(400, 70);
    write_reg(CFG_MAX_LEN, '0);
    run_phase(60, 4);
    write_all($urandom, $urandom_range(1, 300), 8'($urandom), 8'($urandom));
    run_phase(450, 48);

    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("flash_image_programmer_test: clean");
    end else begin
      $display("flash_image_programmer_test: errors");
    end
    $finish;
  end

endmodule
